### design/binco_pkg.sv
`default_nettype none

package binco_pkg;

   localparam int DEFAULT_MAX_TOTAL = 29;

   localparam int TOTAL_W = 5;
   localparam int COEF_W  = 27;
   localparam int PROD_W  = 31;
   localparam int STEP_W  = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } binco_state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic div;
      logic emit;
   } binco_cmd_type;

   typedef struct packed {
      logic k_zero;
      logic last_step;
   } binco_status_type;

   // inverse of an odd value modulo 2**COEF_W by Newton iteration
   function automatic logic [COEF_W-1:0] odd_inverse(input logic [COEF_W-1:0] o);
      logic [COEF_W-1:0] x;
      x = o;
      for (int s = 0; s < 5; s++) begin
         x = x * (COEF_W'(2) - o * x);
      end
      return x;
   endfunction

   localparam logic [COEF_W-1:0] INV_TABLE [8] = '{
      odd_inverse(COEF_W'(1)),  odd_inverse(COEF_W'(3)),
      odd_inverse(COEF_W'(5)),  odd_inverse(COEF_W'(7)),
      odd_inverse(COEF_W'(9)),  odd_inverse(COEF_W'(11)),
      odd_inverse(COEF_W'(13)), odd_inverse(COEF_W'(15))
   };

endpackage

`default_nettype wire

### design/binco_dpath.sv
`default_nettype none

module binco_dpath
   import binco_pkg::*;
#(
   parameter int MAX_TOTAL = DEFAULT_MAX_TOTAL
) (
   input  wire logic               clock,
   input  wire logic [TOTAL_W-1:0] req_total,
   input  wire logic [TOTAL_W-1:0] req_chosen,
   input  wire binco_cmd_type      cmd,
   output binco_status_type        status,
   output logic [COEF_W-1:0]       rsp_coefficient
);

   logic [COEF_W-1:0]  c_ff, c_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [TOTAL_W-1:0] h_ff, h_in;
   logic [STEP_W-1:0]  k_ff, k_in;
   logic [STEP_W-1:0]  i_ff, i_in;
   logic [COEF_W-1:0]  coef_ff, coef_in;

   logic [TOTAL_W-1:0] m_sat;
   logic [TOTAL_W-1:0] diff;
   logic [STEP_W-1:0]  k_load;
   logic [TOTAL_W-1:0] h_load;
   logic [TOTAL_W-1:0] factor;
   logic [1:0]         shift;
   logic [STEP_W-1:0]  odd;
   logic [PROD_W-1:0]  shifted;
   logic [2*COEF_W-1:0] full;

   always_comb begin
      m_sat = (req_total > TOTAL_W'(MAX_TOTAL)) ? TOTAL_W'(MAX_TOTAL) : req_total;
      diff  = m_sat - req_chosen;
      if (req_chosen > m_sat) begin
         k_load = '0;
         h_load = '0;
      end else if (req_chosen < diff) begin
         k_load = req_chosen[STEP_W-1:0];
         h_load = diff;
      end else begin
         k_load = diff[STEP_W-1:0];
         h_load = req_chosen;
      end
   end

   // split the divisor into a power of two and an odd part
   always_comb begin
      if (i_ff[0]) begin
         shift = 2'd0;
      end else if (i_ff[1]) begin
         shift = 2'd1;
      end else if (i_ff[2]) begin
         shift = 2'd2;
      end else begin
         shift = 2'd3;
      end
      odd     = i_ff >> shift;
      shifted = prod_ff >> shift;
      full    = shifted[COEF_W-1:0] * INV_TABLE[odd[STEP_W-1:1]];
      factor  = h_ff + {1'b0, i_ff};
   end

   always_comb begin
      c_in    = c_ff;
      prod_in = prod_ff;
      h_in    = h_ff;
      k_in    = k_ff;
      i_in    = i_ff;
      coef_in = coef_ff;
      if (cmd.load) begin
         c_in = COEF_W'(1);
         h_in = h_load;
         k_in = k_load;
         i_in = STEP_W'(1);
      end
      if (cmd.mul) begin
         prod_in = PROD_W'(c_ff) * PROD_W'(factor);
      end
      if (cmd.div) begin
         c_in = full[COEF_W-1:0];
         i_in = i_ff + STEP_W'(1);
      end
      if (cmd.emit) begin
         coef_in = c_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_ff    <= c_in;
      prod_ff <= prod_in;
      h_ff    <= h_in;
      k_ff    <= k_in;
      i_ff    <= i_in;
      coef_ff <= coef_in;
   end

   assign status.k_zero    = (k_load == '0);
   assign status.last_step = (i_ff == k_ff);
   assign rsp_coefficient  = coef_ff;

endmodule

`default_nettype wire

### design/binco_ctrl.sv
`default_nettype none

module binco_ctrl
   import binco_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire binco_status_type status,
   output binco_cmd_type         cmd
);

   binco_state_type state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.k_zero ? ST_FINISH : ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            state_in = status.last_step ? ST_FINISH : ST_MUL;
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
         end
         ST_FINISH: begin
            cmd.emit = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### design/binomial_coefficient.sv
// Binomial coefficient C(total, chosen).
//
// Request channel: req_valid / req_stall with req_total and req_chosen. A
// transaction is taken when req_valid is high and req_stall is low. A total
// above MAX_TOTAL is saturated to MAX_TOTAL; chosen above total gives 1.
// Response channel: rsp_valid / rsp_stall with rsp_coefficient, one response
// per request, in order.
//
// One request is worked on at a time. With k = min(chosen, total - chosen)
// the block loads the operands, then runs k rounds on the two multipliers,
// each a multiply state (multiply by h + i) and a divide state (exact divide
// by i as a shift and a multiply by the modular inverse of its odd part),
// then moves the result into the output register in the finish state. The
// next request is taken in the cycle after the result is written, even while
// that result still waits in the output register.
//
// Reset clears the controller and the output valid; no request is lost after
// it. While rsp_stall is high the response holds and a finished result waits
// in the datapath until the output register is free.
`default_nettype none

module binomial_coefficient
   import binco_pkg::*;
#(
   parameter int MAX_TOTAL = DEFAULT_MAX_TOTAL
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [TOTAL_W-1:0] req_total,
   input  wire logic [TOTAL_W-1:0] req_chosen,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [COEF_W-1:0]       rsp_coefficient
);

   binco_cmd_type    cmd;
   binco_status_type status;

   binco_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   binco_dpath #(
      .MAX_TOTAL (MAX_TOTAL)
   ) u_dpath (
      .clock           (clock),
      .req_total       (req_total),
      .req_chosen      (req_chosen),
      .cmd             (cmd),
      .status          (status),
      .rsp_coefficient (rsp_coefficient)
   );

endmodule

`default_nettype wire

### design/binco_checker.sv
`default_nettype none

module binco_checker
   import binco_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic [TOTAL_W-1:0] req_chosen,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [COEF_W-1:0]  rsp_coefficient
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_coefficient))
      else $error("stalled response changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   a_trivial_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_chosen == '0 && !rsp_valid
      |=> ##1 (rsp_valid && rsp_coefficient == COEF_W'(1)))
      else $error("empty choice did not give one");

   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_coefficient != '0)
      else $error("zero coefficient");

endmodule

bind binomial_coefficient binco_checker u_checker (.*);

`default_nettype wire
